// ===== design/rpi_pkg.sv =====
package rpi_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned RadixW = 6;
  localparam int unsigned CharW  = 8;

  // parse phase codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ZERO  = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [RadixW-1:0] RADIX_DEC = 6'd10;
  localparam logic [RadixW-1:0] RADIX_HEX = 6'd16;
  localparam logic [RadixW-1:0] RADIX_OCT = 6'd8;
  localparam logic [31:0]       RADIX_MIN = 32'd2;
  localparam logic [31:0]       RADIX_MAX = 32'd36;

  localparam logic [CharW-1:0] CH_NUL    = 8'h00;
  localparam logic [CharW-1:0] CH_ZERO   = 8'h30;
  localparam logic [CharW-1:0] CH_NINE   = 8'h39;
  localparam logic [CharW-1:0] CH_HASH   = 8'h23;
  localparam logic [CharW-1:0] CH_LO_A   = 8'h61;
  localparam logic [CharW-1:0] CH_LO_Z   = 8'h7a;
  localparam logic [CharW-1:0] CH_UP_A   = 8'h41;
  localparam logic [CharW-1:0] CH_UP_Z   = 8'h5a;
  localparam logic [CharW-1:0] CH_LO_X   = 8'h78;
  localparam logic [CharW-1:0] CH_UP_X   = 8'h58;
  localparam logic [CharW-1:0] LETTER_OFS = 8'd10;

  typedef struct packed {
    logic             ok;
    logic [RadixW-1:0] val;
  } digit_t;

  // map a character to its digit value 0..35
  function automatic digit_t decode_digit(input logic [CharW-1:0] c);
    digit_t       d;
    logic [CharW-1:0] v;
    d = '0;
    v = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
      d.ok = 1'b1;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      v = c - CH_LO_A + LETTER_OFS;
      d.ok = 1'b1;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      v = c - CH_UP_A + LETTER_OFS;
      d.ok = 1'b1;
    end
    d.val = v[RadixW-1:0];
    return d;
  endfunction

endpackage

// ===== design/radix_prefixed_integer_parser.sv =====
// Channel | Ports                       | Payload
// --------+-----------------------------+-------------------------------------
// input   | in_tvalid/tready/tdata/tlast| tdata[7:0] = ch, tlast = last
// output  | out_tvalid/tready/tdata/tuser| tdata[63:0] = value, tuser = bad_digit
//
// One character per cycle sustained while no last character waits on a full
// result slot; a word is held in the input register, then updates the parse
// state and, on tlast, loads the result register.
// The per-character step is one 64x6 multiply and add on the accumulator.
// rst_n is synchronous, active low; it clears both valid bits and the state.
// A stalled result only holds back a character marked last; others still pass.
module radix_prefixed_integer_parser
  import rpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value
  output logic        out_tuser   // [0] bad_digit
);

  logic              in_vld_r;
  logic [CharW-1:0]  in_ch_r;
  logic              in_last_r;

  logic [1:0]        phase_r, phase_nxt;
  logic [RadixW-1:0] radix_r, radix_nxt;
  logic [ValueW-1:0] accum_r, accum_nxt;
  logic              err_r, err_nxt;

  logic              out_vld_r;
  logic [ValueW-1:0] out_val_r;
  logic              out_err_r;

  logic              proc;
  digit_t            dig;
  logic [RadixW-1:0] eff_radix;
  logic [ValueW+RadixW-1:0] prod;
  logic [ValueW-1:0] step_val;
  logic [31:0]       low_word;
  logic              do_body;

  // a character marked last needs the result slot free
  assign proc      = in_vld_r && (!in_last_r || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc;

  assign dig       = decode_digit(in_ch_r);
  assign eff_radix = (phase_r == PH_ZERO) ? RADIX_OCT : radix_r;
  assign prod      = accum_r * eff_radix;
  assign step_val  = prod[ValueW-1:0] + ValueW'(dig.val);
  assign low_word  = accum_r[31:0];

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    accum_nxt = accum_r;
    err_nxt   = err_r;
    do_body   = 1'b0;
    case (phase_r)
      PH_START: begin
        if (in_ch_r == CH_NUL) begin
          phase_nxt = PH_DONE;
        end else if (in_ch_r == CH_ZERO) begin
          phase_nxt = PH_ZERO;
        end else begin
          do_body = 1'b1;
        end
      end
      PH_ZERO: begin
        if (in_ch_r == CH_NUL) begin
          phase_nxt = PH_DONE;
        end else if (in_ch_r == CH_LO_X || in_ch_r == CH_UP_X) begin
          radix_nxt = RADIX_HEX;
          phase_nxt = PH_BODY;
        end else begin
          radix_nxt = RADIX_OCT;
          do_body   = 1'b1;
        end
      end
      PH_BODY: do_body = 1'b1;
      default: ;
    endcase

    if (do_body) begin
      phase_nxt = PH_BODY;
      if (in_ch_r == CH_HASH) begin
        // gathered low word becomes the base if in 2..36, else base 10
        if (low_word >= RADIX_MIN && low_word <= RADIX_MAX) begin
          radix_nxt = low_word[RadixW-1:0];
        end else begin
          radix_nxt = RADIX_DEC;
        end
        accum_nxt = '0;
      end else if (dig.ok) begin
        if (dig.val >= eff_radix) begin
          err_nxt = 1'b1;
        end
        accum_nxt = step_val;
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_ch_r   <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      radix_r <= RADIX_DEC;
      accum_r <= '0;
      err_r   <= 1'b0;
    end else if (proc) begin
      if (in_last_r) begin
        phase_r <= PH_START;
        radix_r <= RADIX_DEC;
        accum_r <= '0;
        err_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        radix_r <= radix_nxt;
        accum_r <= accum_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (proc && in_last_r) begin
      out_val_r <= accum_nxt;
      out_err_r <= err_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_err_r;

`ifndef NO_ASSERTIONS
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(proc && in_last_r))
    else $error("result appeared without a last character");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_last_r) |=> (phase_r == PH_START && radix_r == RADIX_DEC &&
                             accum_r == '0 && !err_r))
    else $error("parse state not cleared after last character");

  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (radix_r >= RADIX_MIN[RadixW-1:0] && radix_r <= RADIX_MAX[RadixW-1:0]))
    else $error("radix out of range");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && in_last_r && out_vld_r && !out_tready))
    else $error("input stalled without a blocked result");
`endif

endmodule

// ===== sim/radix_prefixed_integer_parser_test.sv =====
`timescale 1ns / 100ps

module radix_prefixed_integer_parser_test
  import rpi_pkg::*;
();

  typedef struct {
    logic [63:0] value;
    logic        bad_digit;
  } parse_result_t;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_SPARSE
  } ready_pattern_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] ch
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [63:0] value
  logic        out_tuser;  // [0] bad_digit

  radix_prefixed_integer_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // parser state as the testbench tracks it
  logic [1:0]        tok_phase;
  logic [RadixW-1:0] tok_radix;
  logic [63:0]       tok_accum;
  logic              tok_bad;

  parse_result_t  expected_results[$];
  int             mismatch_count = 0;
  int             chars_sent = 0;
  int             burst_left = 0;
  int             stall_tick = 0;
  ready_pattern_t stall_mode = READY_ALWAYS;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void clear_token();
    tok_phase = PH_START;
    tok_radix = RADIX_DEC;
    tok_accum = '0;
    tok_bad   = 1'b0;
  endfunction

  // one character of the digit body: '#', a digit, or the end of the parse
  function automatic void take_body_char(input logic [7:0] c);
    logic [RadixW-1:0] digit;
    logic              is_digit;
    logic [31:0]       low_word;
    digit    = '0;
    is_digit = 1'b1;
    low_word = tok_accum[31:0];
    if (c == CH_HASH) begin
      if (low_word >= RADIX_MIN && low_word <= RADIX_MAX) begin
        tok_radix = low_word[RadixW-1:0];
      end else begin
        tok_radix = RADIX_DEC;
      end
      tok_accum = '0;
      return;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = RadixW'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      digit = RadixW'(c - CH_LO_A + LETTER_OFS);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      digit = RadixW'(c - CH_UP_A + LETTER_OFS);
    end else begin
      is_digit = 1'b0;
    end
    if (!is_digit) begin
      tok_phase = PH_DONE;
    end else begin
      if (digit >= tok_radix) tok_bad = 1'b1;
      tok_accum = tok_accum * tok_radix + digit;
    end
  endfunction

  function automatic void track_char(input logic [7:0] c, input logic lst);
    parse_result_t res;
    case (tok_phase)
      PH_START: begin
        if (c == CH_NUL) begin
          tok_phase = PH_DONE;
        end else if (c == CH_ZERO) begin
          tok_phase = PH_ZERO;
        end else begin
          tok_phase = PH_BODY;
          take_body_char(c);
        end
      end
      PH_ZERO: begin
        if (c == CH_NUL) begin
          tok_phase = PH_DONE;
        end else if (c == CH_LO_X || c == CH_UP_X) begin
          tok_radix = RADIX_HEX;
          tok_phase = PH_BODY;
        end else begin
          tok_radix = RADIX_OCT;
          tok_phase = PH_BODY;
          take_body_char(c);
        end
      end
      PH_BODY: take_body_char(c);
      default: ;
    endcase
    if (lst) begin
      res.value     = tok_accum;
      res.bad_digit = tok_bad;
      expected_results.push_back(res);
      clear_token();
    end
  endfunction

  // send one word, inserting a random gap between bursts
  task automatic send_char(input logic [7:0] c, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_char(c, lst);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input bit end_token);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], end_token && (i == s.len() - 1));
    end
  endtask

  task automatic test_prefixes();
    send_text("0", 1);
    send_text("0XfF", 1);
    send_text("09", 1);  // 9 is too great for octal
  endtask

  task automatic test_base_change();
    send_text("36#Zz", 1);
    send_text("1#5", 1);  // base 1 falls back to decimal
  endtask

  task automatic test_terminators();
    send_char(CH_NUL, 1'b1);
    send_text("0", 0);
    send_char(CH_NUL, 1'b1);
    send_text("12 9", 1);
    send_text("7", 0);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_random_tokens(input int n_chars);
    int          start;
    int          kind;
    int          len;
    int          radix;
    int          base;
    int          digit;
    logic [63:0] big;
    logic [7:0]  c;
    string       s;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        // noise: raw bytes
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send_char(8'($urandom_range(0, 255)), i == len - 1);
        end
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            s = "";
            radix = 10;
          end
          1: begin
            s = "0";
            radix = 8;
          end
          2: begin
            s = $urandom_range(0, 1) ? "0x" : "0X";
            radix = 16;
          end
          default: begin
            case ($urandom_range(0, 9))
              0: base = $urandom_range(0, 1);
              1: base = $urandom_range(37, 99);
              default: base = $urandom_range(2, 36);
            endcase
            if ($urandom_range(0, 4) == 0) begin
              // only the low word selects the base
              big = 64'(base) + (64'($urandom_range(1, 7)) << 32);
              s = $sformatf("%0d#", big);
            end else begin
              s = $sformatf("%0d#", base);
            end
            radix = (base >= 2 && base <= 36) ? base : 10;
          end
        endcase
        if ($urandom_range(0, 9) == 0) len = $urandom_range(14, 30);
        else len = $urandom_range((s.len() == 0) ? 1 : 0, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 24) == 0) digit = $urandom_range(0, 35);
          else digit = $urandom_range(0, radix - 1);
          if (digit < 10) c = CH_ZERO + 8'(digit);
          else if ($urandom_range(0, 1)) c = CH_LO_A + 8'(digit) - LETTER_OFS;
          else c = CH_UP_A + 8'(digit) - LETTER_OFS;
          s = {s, $sformatf("%c", c)};
        end
        if ($urandom_range(0, 99) < 15) begin
          // end the parse early with a NUL or random byte (a digit continues it), then trailing characters
          send_text(s, 0);
          len = $urandom_range(0, 4);
          c = ($urandom_range(0, 1) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
          send_char(c, len == 0);
          for (int i = 0; i < len; i++) begin
            send_char(8'($urandom_range(0, 255)), i == len - 1);
          end
        end else begin
          send_text(s, 1);
        end
      end
    end
  endtask

  // receiver stall pattern, picked at random and switched periodically
  always @(posedge clk) begin
    if (stall_tick % 200 == 0) stall_mode = ready_pattern_t'($urandom_range(0, 3));
    stall_tick++;
    case (stall_mode)
      READY_ALWAYS:   out_tready <= 1'b1;
      READY_COIN:     out_tready <= 1'($urandom_range(0, 1));
      READY_PERIODIC: out_tready <= (stall_tick % 7) < 4;
      default:        out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word value=%h bad_digit=%b",
                                  out_tdata, out_tuser));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata !== want.value) begin
          report_mismatch($sformatf("value %h, want %h", out_tdata, want.value));
        end
        if (out_tuser !== want.bad_digit) begin
          report_mismatch($sformatf("bad_digit %b, want %b (value %h)",
                                    out_tuser, want.bad_digit, want.value));
        end
      end
    end
  end

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    clear_token();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_prefixes();
    test_base_change();
    test_terminators();
    test_random_tokens(1550);

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[radix_prefixed_integer_parser] OK");
    end else begin
      $display("[radix_prefixed_integer_parser] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("[radix_prefixed_integer_parser] ERROR");
    $finish;
  end

endmodule
